// File: rtl/tlv_record_deframer_unit_assert.svh
// Assertion macros used by the checker module of the record deframer.
`ifndef TLV_RECORD_DEFRAMER_UNIT_ASSERT_SVH
`define TLV_RECORD_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TLVD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TLVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tlvd_pkg.sv
`timescale 1ns / 1ps

package tlvd_pkg;

    localparam int HEADER_BYTES        = 8;
    localparam int VERSION_BYTES       = 4;
    localparam int DEFAULT_OFFSET_BITS = 32;
    localparam int WORD_W              = 32;
    localparam int HEADER_W            = HEADER_BYTES * 8;
    localparam int HDR_CNT_W           = $clog2(HEADER_BYTES);
    localparam int VER_CNT_W           = $clog2(VERSION_BYTES + 1);
    localparam int IN_TDATA_W          = 8;
    localparam int OUT_FIELDS_W        = 5 * WORD_W + 2;
    localparam int OUT_TDATA_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W          = 1;
    localparam int QUEUE_DEPTH         = 3;
    localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_SCHEMA_TAG      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_VERSION = 1'd1;

    // Result kinds, carried on m_tuser.
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DEFAULT = 2'd0,
        STATUS_FOUND   = 2'd1,
        STATUS_SHORT   = 2'd2
    } version_status_t;

    typedef struct packed {
        logic                kind;
        logic [WORD_W-1:0]   record_tag;
        logic [WORD_W-1:0]   record_length;
        logic [WORD_W-1:0]   payload_offset;
        logic [WORD_W-1:0]   version;
        version_status_t     version_status;
        logic [WORD_W-1:0]   leftover_bytes;
        logic                end_of_run;
    } result_t;

endpackage

// File: rtl/tlv_record_deframer_unit.sv
`timescale 1ns / 1ps

// A result request is queued from the byte that causes it and shown on the m_ side once the
// results ahead of it are taken. Throughput: one byte per cycle while s_tready is high; each
// byte updates counters and shift registers. A byte may yield a descriptor and a summary,
// and the three-entry result queue lets the input stall only while two or more results wait.
// Reset (aresetn low, synchronous) clears parse state, both registers and the result queue.
module tlv_record_deframer_unit
    import tlvd_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Configuration write port.
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [WORD_W-1:0]       cfg_wdata,
    // Byte stream in.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                    s_tuser,   // [0] has_byte
    input  logic                    s_tlast,   // last_byte
    // Results out.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // From bit 0 up: record_tag, record_length, payload_offset, version,
    // version_status, leftover_bytes, zero padding.
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    output logic                    m_tuser,   // [0] kind
    output logic                    m_tlast    // end_of_run
);

    localparam int EXT_W = (OFFSET_BITS > WORD_W) ? OFFSET_BITS : WORD_W;
    localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);
    localparam logic [VER_CNT_W-1:0] VER_FULL = VER_CNT_W'(VERSION_BYTES);

    // Takes the low word of an offset-sized counter, zero-extending narrow counters.
    function automatic logic [WORD_W-1:0] low_word(input logic [OFFSET_BITS-1:0] v);
        logic [EXT_W-1:0] w;
        w = EXT_W'(v);
        return w[WORD_W-1:0];
    endfunction

    // Configuration registers.
    logic [WORD_W-1:0] schema_tag_reg;
    logic [WORD_W-1:0] default_version_reg;

    // Parse state.
    logic [HDR_CNT_W-1:0]   header_count_reg,   header_count_next;
    logic                   in_payload_reg,     in_payload_next;
    logic [HEADER_W-1:0]    header_shift_reg,   header_shift_next;
    logic [WORD_W-1:0]      payload_left_reg,   payload_left_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg,    byte_offset_next;
    logic [OFFSET_BITS-1:0] record_start_reg,   record_start_next;
    logic [OFFSET_BITS-1:0] leftover_reg,       leftover_next;
    logic [WORD_W-1:0]      cur_tag_reg,        cur_tag_next;
    logic [WORD_W-1:0]      cur_len_reg,        cur_len_next;
    logic                   schema_seen_reg,    schema_seen_next;
    logic                   capture_active_reg, capture_active_next;
    logic [WORD_W-1:0]      version_shift_reg,  version_shift_next;
    logic [VER_CNT_W-1:0]   version_bytes_reg,  version_bytes_next;
    logic [WORD_W-1:0]      version_latch_reg,  version_latch_next;
    version_status_t        status_latch_reg,   status_latch_next;

    // Result queue: entry 0 is the head shown on the m_ side.
    result_t                q_reg [QUEUE_DEPTH];
    result_t                q_next [QUEUE_DEPTH];
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    logic                   accept;
    logic                   pop;
    logic [QUEUE_CNT_W-1:0] cnt_after;
    logic [QUEUE_CNT_W-1:0] push_n;
    result_t                res_a, res_b;

    // The input is taken whenever at least two queue slots are free, which
    // covers the worst case of a descriptor and a summary from one byte.
    assign s_tready = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;

    assign m_tdata = {{PAD_W{1'b0}},
                      q_reg[0].leftover_bytes,
                      q_reg[0].version_status,
                      q_reg[0].version,
                      q_reg[0].payload_offset,
                      q_reg[0].record_length,
                      q_reg[0].record_tag};
    assign m_tuser = q_reg[0].kind;
    assign m_tlast = q_reg[0].end_of_run;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            schema_tag_reg      <= '0;
            default_version_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SCHEMA_TAG: begin
                    schema_tag_reg <= cfg_wdata;
                end
                REG_DEFAULT_VERSION: begin
                    default_version_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Per-byte parse step. Everything a byte does to the state, and the
    // results it causes, is worked out here in one pass.
    always_comb begin
        logic                   data_has;
        logic                   data_last;
        logic [7:0]             data_byte;
        logic                   off_sat;
        logic [OFFSET_BITS-1:0] off_inc;
        logic [HEADER_W-1:0]    shift_new;
        logic [WORD_W-1:0]      new_tag;
        logic [WORD_W-1:0]      new_len;
        logic                   capture_now;
        logic                   completed;
        result_t                desc;
        result_t                summ;
        logic                   have_desc;

        data_byte = s_tdata[7:0];
        data_has  = s_tuser;
        data_last = s_tlast;

        // The offset counter sticks at all ones.
        off_sat = &byte_offset_reg;
        off_inc = off_sat ? byte_offset_reg : byte_offset_reg + OFFSET_BITS'(1);

        shift_new   = {data_byte, header_shift_reg[HEADER_W-1:8]};
        new_tag     = shift_new[WORD_W-1:0];
        new_len     = shift_new[HEADER_W-1:WORD_W];
        capture_now = !schema_seen_reg && (new_tag == schema_tag_reg);
        completed   = 1'b0;
        have_desc   = 1'b0;
        desc        = '0;
        summ        = '0;

        header_count_next   = header_count_reg;
        in_payload_next     = in_payload_reg;
        header_shift_next   = header_shift_reg;
        payload_left_next   = payload_left_reg;
        byte_offset_next    = byte_offset_reg;
        record_start_next   = record_start_reg;
        leftover_next       = leftover_reg;
        cur_tag_next        = cur_tag_reg;
        cur_len_next        = cur_len_reg;
        schema_seen_next    = schema_seen_reg;
        capture_active_next = capture_active_reg;
        version_shift_next  = version_shift_reg;
        version_bytes_next  = version_bytes_reg;
        version_latch_next  = version_latch_reg;
        status_latch_next   = status_latch_reg;

        if (accept && data_has) begin
            if (!in_payload_reg) begin
                header_shift_next = shift_new;
                if (header_count_reg == HDR_LAST) begin
                    // Header complete: tag in the low word, length in the high word.
                    header_count_next = '0;
                    cur_tag_next      = new_tag;
                    cur_len_next      = new_len;
                    record_start_next = off_inc;
                    if (capture_now) begin
                        capture_active_next = 1'b1;
                        version_bytes_next  = '0;
                    end
                    if (new_len == '0) begin
                        // An empty record ends on its last header byte; an empty
                        // schema record is too short to hold a version.
                        completed = 1'b1;
                        if (capture_now) begin
                            capture_active_next = 1'b0;
                            schema_seen_next    = 1'b1;
                            status_latch_next   = STATUS_SHORT;
                        end
                        have_desc            = 1'b1;
                        desc.kind            = KIND_RECORD;
                        desc.record_tag      = new_tag;
                        desc.payload_offset  = low_word(off_inc);
                    end else begin
                        in_payload_next   = 1'b1;
                        payload_left_next = new_len;
                    end
                end else begin
                    header_count_next = header_count_reg + HDR_CNT_W'(1);
                end
            end else begin
                // The first four payload bytes of the schema record form the version.
                if (capture_active_reg && (version_bytes_reg < VER_FULL)) begin
                    version_shift_next = {data_byte, version_shift_reg[WORD_W-1:8]};
                    version_bytes_next = version_bytes_reg + VER_CNT_W'(1);
                end
                payload_left_next = payload_left_reg - WORD_W'(1);
                if (payload_left_reg == WORD_W'(1)) begin
                    completed       = 1'b1;
                    in_payload_next = 1'b0;
                    if (capture_active_reg) begin
                        capture_active_next = 1'b0;
                        schema_seen_next    = 1'b1;
                        if (|cur_len_reg[WORD_W-1:2]) begin
                            status_latch_next  = STATUS_FOUND;
                            version_latch_next = version_shift_next;
                        end else begin
                            status_latch_next = STATUS_SHORT;
                        end
                    end
                    have_desc            = 1'b1;
                    desc.kind            = KIND_RECORD;
                    desc.record_tag      = cur_tag_reg;
                    desc.record_length   = cur_len_reg;
                    desc.payload_offset  = low_word(record_start_reg);
                end
            end

            // Bytes since the end of the last complete record; this runs in
            // step with the offset counter, so it stops when that saturates.
            if (completed) begin
                leftover_next = '0;
            end else if (!off_sat) begin
                leftover_next = leftover_reg + OFFSET_BITS'(1);
            end
            byte_offset_next = off_inc;
        end

        desc.end_of_run = !data_last;

        summ.kind           = KIND_SUMMARY;
        summ.version        = (status_latch_next == STATUS_FOUND) ? version_latch_next
                                                                  : default_version_reg;
        summ.version_status = status_latch_next;
        summ.leftover_bytes = low_word(leftover_next);
        summ.end_of_run     = 1'b1;

        // The end of the buffer returns all parse state to its reset values.
        if (accept && data_last) begin
            header_count_next   = '0;
            in_payload_next     = 1'b0;
            header_shift_next   = '0;
            payload_left_next   = '0;
            byte_offset_next    = '0;
            record_start_next   = '0;
            leftover_next       = '0;
            cur_tag_next        = '0;
            cur_len_next        = '0;
            schema_seen_next    = 1'b0;
            capture_active_next = 1'b0;
            version_shift_next  = '0;
            version_bytes_next  = '0;
            version_latch_next  = '0;
            status_latch_next   = STATUS_DEFAULT;
        end

        // Order the results: a descriptor always precedes the summary.
        push_n = '0;
        res_a  = desc;
        res_b  = summ;
        if (accept) begin
            if (have_desc && data_last) begin
                push_n = QUEUE_CNT_W'(2);
            end else if (have_desc) begin
                push_n = QUEUE_CNT_W'(1);
            end else if (data_last) begin
                push_n = QUEUE_CNT_W'(1);
                res_a  = summ;
            end
        end
    end

    // Result queue update: pop shifts towards the head, pushes append behind.
    always_comb begin
        result_t q_shift [QUEUE_DEPTH];

        q_shift = q_reg;
        if (pop) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                q_shift[i] = q_reg[i + 1];
            end
        end
        cnt_after = count_reg - QUEUE_CNT_W'(pop);

        q_next = q_shift;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((push_n != '0) && (QUEUE_CNT_W'(i) == cnt_after)) begin
                q_next[i] = res_a;
            end
            if ((push_n == QUEUE_CNT_W'(2)) &&
                (QUEUE_CNT_W'(i) == cnt_after + QUEUE_CNT_W'(1))) begin
                q_next[i] = res_b;
            end
        end
        count_next = cnt_after + push_n;
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg          <= '0;
            header_count_reg   <= '0;
            in_payload_reg     <= 1'b0;
            header_shift_reg   <= '0;
            payload_left_reg   <= '0;
            byte_offset_reg    <= '0;
            record_start_reg   <= '0;
            leftover_reg       <= '0;
            cur_tag_reg        <= '0;
            cur_len_reg        <= '0;
            schema_seen_reg    <= 1'b0;
            capture_active_reg <= 1'b0;
            version_shift_reg  <= '0;
            version_bytes_reg  <= '0;
            version_latch_reg  <= '0;
            status_latch_reg   <= STATUS_DEFAULT;
        end else begin
            count_reg          <= count_next;
            header_count_reg   <= header_count_next;
            in_payload_reg     <= in_payload_next;
            header_shift_reg   <= header_shift_next;
            payload_left_reg   <= payload_left_next;
            byte_offset_reg    <= byte_offset_next;
            record_start_reg   <= record_start_next;
            leftover_reg       <= leftover_next;
            cur_tag_reg        <= cur_tag_next;
            cur_len_reg        <= cur_len_next;
            schema_seen_reg    <= schema_seen_next;
            capture_active_reg <= capture_active_next;
            version_shift_reg  <= version_shift_next;
            version_bytes_reg  <= version_bytes_next;
            version_latch_reg  <= version_latch_next;
            status_latch_reg   <= status_latch_next;
        end
    end

endmodule

// File: rtl/tlvd_checker.sv
`timescale 1ns / 1ps
`include "tlv_record_deframer_unit_assert.svh"

module tlvd_checker
    import tlvd_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [OUT_TDATA_W-1:0]  m_tdata,
    input logic                    m_tuser,
    input logic                    m_tlast
);

    // A stalled result request keeps its contents.
    `TLVD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // The summary is always the final result of its byte.
    `TLVD_ASSERT_IMPLY(a_summary_last, aclk, aresetn, m_tvalid && (m_tuser == KIND_SUMMARY), m_tlast, "summary without end_of_run")

    // Descriptors carry no version, status or leftover count.
    `TLVD_ASSERT_IMPLY(a_desc_zero, aclk, aresetn, m_tvalid && (m_tuser == KIND_RECORD), m_tdata[161:96] == '0, "descriptor with summary fields set")

    // Summaries carry no tag, length or offset.
    `TLVD_ASSERT_IMPLY(a_summ_zero, aclk, aresetn, m_tvalid && (m_tuser == KIND_SUMMARY), m_tdata[95:0] == '0, "summary with descriptor fields set")

    // The version status never takes its unused code.
    `TLVD_ASSERT_IMPLY(a_status_code, aclk, aresetn, m_tvalid, m_tdata[129:128] != 2'd3, "unused version status code")

endmodule

bind tlv_record_deframer_unit tlvd_checker u_tlvd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
